/* hw/rtl/tmhq_pkg.sv */
// ----------------------------------------------------------------------------
// Task min-heap queue package
// Shared types and codes for the heap controller, the heap datapath and the
// top level.
// ----------------------------------------------------------------------------
package tmhq_pkg;

   // Operation codes on the request channel. The unused code is handled as a peek.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_PEEK   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // One heap entry as it sits in the heap memory.
   typedef struct packed {
      logic [15:0] task_id;
      logic [30:0] deadline;
      logic [30:0] arrival;
   } entry_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_WR_ENT,
      ST_ROOT_RD,
      ST_ROOT_TAKE,
      ST_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath, one per cycle.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_UP_READ,
      OP_UP_STEP,
      OP_WR_ENT,
      OP_ROOT_READ,
      OP_ROOT_TAKE,
      OP_LAST_TAKE,
      OP_DN_READ_L,
      OP_DN_READ_R,
      OP_DN_STEP,
      OP_POST
   } dp_op_type;

   // Status flags from the datapath back to the controller.
   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic full;
      logic empty;
      logic last_one;
      logic parent_zero;
      logic up_less;
      logic has_left;
      logic dn_move;
      logic rsp_free;
   } dp_status_type;

endpackage

/* hw/rtl/task_min_heap_queue_top.sv */
// A refused request (remove or peek on an empty heap, insert on a full heap) skips the
// heap walk; a peek reads the root, an insert climbs by parent compares, and a remove
// takes the root and, if entries remain, the last entry, then descends by child compares.
// The block takes one operation at a time: a new request is taken only after the
// previous result is posted, and posting waits while an earlier result is stalled.
// Reset (synchronous, active high) empties the heap and selects deadline order.
// ----------------------------------------------------------------------------
// Task min-heap queue top level
// Binary min-heap of tasks ordered by deadline or arrival time, with a
// controller sequencing the sift walks over a shared heap memory datapath.
// ----------------------------------------------------------------------------
module task_min_heap_queue_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_task_id,
   input  logic [30:0] req_deadline,
   input  logic [30:0] req_arrival,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_task_id,
   output logic [30:0] rsp_out_deadline,
   output logic [30:0] rsp_out_arrival,
   output logic [6:0]  rsp_count,
   // Configuration write channel for the key mode register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_key_mode
);
   import tmhq_pkg::*;

   dp_op_type     op;
   dp_status_type status;
   logic          req_ready;
   logic          csr_we;

   // The key mode register takes a write in any cycle. It should only change
   // while the heap is empty; otherwise the existing layout is kept as is.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // The block takes a request transfer only while the controller is idle.
   // A finished result sits in the output register in the datapath, so a new
   // request can be taken while the previous result still waits.
   assign req_stall = !req_ready;

   // The controller walks through decode, sift-up or sift-down steps and the
   // final write of the moving entry, one command to the datapath per cycle.
   tmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .op        (op)
   );

   // The datapath holds the heap memory and moves entries along a "hole":
   // the moving entry stays in a register and is written once at its final
   // slot, which leaves the same layout as swapping at every level.
   tmhq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_deadline     (req_deadline),
      .req_arrival      (req_arrival),
      .csr_we           (csr_we),
      .csr_key_mode     (csr_key_mode),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_task_id  (rsp_out_task_id),
      .rsp_out_deadline (rsp_out_deadline),
      .rsp_out_arrival  (rsp_out_arrival),
      .rsp_count        (rsp_count)
   );

   // The block stalls requests in the cycle after a request transfer.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("request taken again right after a transfer");

   // A refused insert reports a full heap.
   a_full_count: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_count == 7'(CAPACITY))
   ) else $error("full status with a heap that is not full");

   // An empty status comes only with an empty heap.
   a_empty_count: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_count == 7'd0)
   ) else $error("empty status with entries held");

   // A failed operation returns an all-zero entry.
   a_fail_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_out_task_id == '0 && rsp_out_deadline == '0 && rsp_out_arrival == '0)
   ) else $error("nonzero entry on a failed operation");

endmodule

/* hw/rtl/tmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// Task min-heap queue controller
// Sequences one heap operation at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module tmhq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  tmhq_pkg::dp_status_type status,
   output logic                    req_ready,
   output tmhq_pkg::dp_op_type     op
);
   import tmhq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_insert) begin
               if (status.full) begin
                  state_in = ST_DONE;
               end else if (status.empty) begin
                  state_in = ST_WR_ENT;
               end else begin
                  state_in = ST_UP_RD;
               end
            end else if (status.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ROOT_RD;
            end
         end
         ST_UP_RD: begin
            op       = OP_UP_READ;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            op = OP_UP_STEP;
            if (status.up_less && !status.parent_zero) begin
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_WR_ENT;
            end
         end
         ST_WR_ENT: begin
            op       = OP_WR_ENT;
            state_in = ST_DONE;
         end
         ST_ROOT_RD: begin
            op       = OP_ROOT_READ;
            state_in = ST_ROOT_TAKE;
         end
         ST_ROOT_TAKE: begin
            op = OP_ROOT_TAKE;
            if (!status.is_remove || status.last_one) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            op       = OP_LAST_TAKE;
            state_in = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            op = OP_DN_READ_L;
            if (status.has_left) begin
               state_in = ST_DN_RDR;
            end else begin
               state_in = ST_WR_ENT;
            end
         end
         ST_DN_RDR: begin
            op       = OP_DN_READ_R;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            op = OP_DN_STEP;
            if (status.dn_move) begin
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_WR_ENT;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               op       = OP_POST;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/tmhq_dpath.sv */
// ----------------------------------------------------------------------------
// Task min-heap queue datapath
// Heap memory, moving-entry and index registers, key compares and the
// result output register.
// ----------------------------------------------------------------------------
module tmhq_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tmhq_pkg::dp_op_type     op,
   input  logic [1:0]              req_kind,
   input  logic [15:0]             req_task_id,
   input  logic [30:0]             req_deadline,
   input  logic [30:0]             req_arrival,
   input  logic                    csr_we,
   input  logic                    csr_key_mode,
   input  logic                    rsp_stall,
   output tmhq_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_out_task_id,
   output logic [30:0]             rsp_out_deadline,
   output logic [30:0]             rsp_out_arrival,
   output logic [6:0]              rsp_count
);
   import tmhq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = IW + 2;

   function automatic logic [30:0] key_of(input entry_type e, input logic mode);
      return mode ? e.arrival : e.deadline;
   endfunction

   // Heap storage, one entry per slot.
   entry_type heap_mem [CAPACITY];
   entry_type rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          wr_en;
   entry_type     wr_data;

   logic          key_mode_ff, key_mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    kind_ff, kind_in;
   entry_type     ent_ff, ent_in;
   logic [IW-1:0] idx_ff, idx_in;
   entry_type     best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic          best_child_ff, best_child_in;
   logic [1:0]    res_status_ff, res_status_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [6:0]    rsp_count_ff, rsp_count_in;

   logic [IW-1:0] parent_pos;
   logic [PW-1:0] left_pos;
   logic [PW-1:0] right_pos;
   logic [PW-1:0] cnt_ext;
   logic          is_full;
   logic          is_empty;
   logic          has_left;
   logic          has_right;
   logic          up_less;
   logic          right_wins;
   logic          dn_move;

   assign parent_pos = IW'((idx_ff - IW'(1)) >> 1);
   assign left_pos   = {1'b0, idx_ff, 1'b1};
   assign right_pos  = PW'(left_pos + PW'(1));
   assign cnt_ext    = PW'(cnt_ff);
   assign is_full    = (cnt_ff == CW'(CAPACITY));
   assign is_empty   = (cnt_ff == '0);
   assign has_left   = (left_pos < cnt_ext);
   assign has_right  = (right_pos < cnt_ext);
   assign up_less    = (key_of(ent_ff, key_mode_ff) < key_of(rd_data_ff, key_mode_ff));
   assign right_wins = has_right &&
                       (key_of(rd_data_ff, key_mode_ff) < key_of(best_ff, key_mode_ff));
   assign dn_move    = right_wins || best_child_ff;

   assign status.is_insert   = (kind_ff == KIND_INSERT);
   assign status.is_remove   = (kind_ff == KIND_REMOVE);
   assign status.full        = is_full;
   assign status.empty       = is_empty;
   assign status.last_one    = (cnt_ff == CW'(1));
   assign status.parent_zero = (parent_pos == '0);
   assign status.up_less     = up_less;
   assign status.has_left    = has_left;
   assign status.dn_move     = dn_move;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      key_mode_in   = csr_we ? csr_key_mode : key_mode_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      ent_in        = ent_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_child_in = best_child_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = ent_ff;
      case (op)
         OP_LOAD: begin
            kind_in      = req_kind;
            ent_in       = '{task_id: req_task_id, deadline: req_deadline,
                             arrival: req_arrival};
            idx_in       = IW'(cnt_ff);
            res_entry_in = '0;
            if (req_kind == KIND_INSERT) begin
               res_status_in = is_full ? STATUS_FULL : STATUS_OK;
            end else begin
               res_status_in = is_empty ? STATUS_EMPTY : STATUS_OK;
            end
         end
         OP_UP_READ: begin
            rd_addr = parent_pos;
         end
         OP_UP_STEP: begin
            // The parent moves down into the hole when the new entry is smaller.
            if (up_less) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               idx_in  = parent_pos;
            end
         end
         OP_WR_ENT: begin
            wr_en = 1'b1;
            if (kind_ff == KIND_INSERT) begin
               cnt_in = CW'(cnt_ff + CW'(1));
            end
         end
         OP_ROOT_READ: begin
            rd_addr = '0;
         end
         OP_ROOT_TAKE: begin
            res_entry_in = rd_data_ff;
            rd_addr      = IW'(cnt_ff - CW'(1));
            if (kind_ff == KIND_REMOVE) begin
               cnt_in = CW'(cnt_ff - CW'(1));
            end
         end
         OP_LAST_TAKE: begin
            ent_in = rd_data_ff;
            idx_in = '0;
         end
         OP_DN_READ_L: begin
            rd_addr = IW'(left_pos);
         end
         OP_DN_READ_R: begin
            rd_addr = IW'(right_pos);
            if (key_of(rd_data_ff, key_mode_ff) < key_of(ent_ff, key_mode_ff)) begin
               best_in       = rd_data_ff;
               best_idx_in   = IW'(left_pos);
               best_child_in = 1'b1;
            end else begin
               best_in       = ent_ff;
               best_idx_in   = idx_ff;
               best_child_in = 1'b0;
            end
         end
         OP_DN_STEP: begin
            // The smaller child moves up into the hole.
            if (dn_move) begin
               wr_en   = 1'b1;
               wr_data = right_wins ? rd_data_ff : best_ff;
               idx_in  = right_wins ? IW'(right_pos) : best_idx_ff;
            end
         end
         OP_POST: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_entry_in  = res_entry_ff;
            rsp_count_in  = 7'(cnt_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_mode_ff  <= key_mode_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ent_ff        <= ent_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_child_ff <= best_child_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_task_id  = rsp_entry_ff.task_id;
   assign rsp_out_deadline = rsp_entry_ff.deadline;
   assign rsp_out_arrival  = rsp_entry_ff.arrival;
   assign rsp_count        = rsp_count_ff;

endmodule
